[hw/rtl/sorted_pair_multiset_index_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sorted pair multiset index
// ----------------------------------------------------------------------------
`ifndef SORTED_PAIR_MULTISET_INDEX_ASSERT_SVH
`define SORTED_PAIR_MULTISET_INDEX_ASSERT_SVH

// Check a property on every clock edge outside reset
`define SPMI_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("spmi assertion failed");

// Check that a condition is followed in the next cycle by another
`define SPMI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spmi sequence assertion failed");

`endif

[hw/rtl/spmi_pkg.sv]
// ----------------------------------------------------------------------------
// spmi_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spmi_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int COUNT_WIDTH = 16;
    localparam int VAL_W       = 32;
    localparam int KEY_W       = 2 * VAL_W;
    localparam int ENTRY_W     = KEY_W + COUNT_WIDTH;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [VAL_W-1:0]       SIGN_FLIP = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [1:0] {
        MODE_INSERT   = 2'd0,
        MODE_LOOKUP   = 2'd1,
        MODE_READ_FWD = 2'd2,
        MODE_READ_REV = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_RDWAIT, S_SRCH, S_CMP, S_DECIDE,
        S_UPD, S_SHRD, S_SHWR, S_INS, S_FIN
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    load;
        logic    srch_init;
        logic    init_rev;
        logic    srch_rd;
        logic    srch_cmp;
        logic    upd_wr;
        logic    sh_init;
        logic    sh_rd;
        logic    sh_wr;
        logic    ins_wr;
        logic    rd_rd;
        logic    commit;
        logic    fin;
        status_t fin_status;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        mode_t mode;
        logic  lo_lt_hi;
        logic  found;
        logic  full;
        logic  sh_more;
        logic  idx_ok;
        logic  rev;
        logic  out_free;
    } stat_t;

    // Key whose unsigned order matches the signed order of (major, minor)
    function automatic logic [KEY_W-1:0] make_key(input logic [VAL_W-1:0] major,
                                                   input logic [VAL_W-1:0] minor);
        return {major ^ SIGN_FLIP, minor ^ SIGN_FLIP};
    endfunction

endpackage

[hw/rtl/spmi_ctrl.sv]
// ----------------------------------------------------------------------------
// spmi_ctrl
// Sequencer for search, shift, insert, update and read operations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spmi_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  spmi_pkg::mode_t in_mode,
    input  spmi_pkg::stat_t stat,
    output spmi_pkg::cmd_t  cmd
);
    import spmi_pkg::*;

    state_t  state_reg, state_next;
    status_t fin_reg, fin_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fin_reg   <= STAT_OK;
        end else begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next     = state_reg;
        fin_next       = fin_reg;
        cmd            = '0;
        cmd.fin_status = fin_reg;
        s_tready       = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                fin_next = STAT_OK;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (in_mode inside {MODE_INSERT, MODE_LOOKUP}) begin
                        state_next = S_SRCH;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                if (stat.idx_ok) begin
                    cmd.rd_rd  = 1'b1;
                    state_next = S_RDWAIT;
                end else begin
                    fin_next   = STAT_RANGE;
                    state_next = S_FIN;
                end
            end
            S_RDWAIT: begin
                state_next = S_FIN;
            end
            S_SRCH: begin
                if (stat.lo_lt_hi) begin
                    cmd.srch_rd = 1'b1;
                    state_next  = S_CMP;
                end else begin
                    state_next = S_DECIDE;
                end
            end
            S_CMP: begin
                cmd.srch_cmp = 1'b1;
                state_next   = S_SRCH;
            end
            S_DECIDE: begin
                if (stat.mode == MODE_LOOKUP) begin
                    state_next = S_FIN;
                end else if (stat.found) begin
                    state_next = S_UPD;
                end else if (!stat.rev && stat.full) begin
                    fin_next   = STAT_FULL;
                    state_next = S_FIN;
                end else begin
                    cmd.sh_init = 1'b1;
                    state_next  = S_SHRD;
                end
            end
            S_UPD, S_INS: begin
                cmd.upd_wr = (state_reg == S_UPD);
                cmd.ins_wr = (state_reg == S_INS);
                if (!stat.rev) begin
                    cmd.srch_init = 1'b1;
                    cmd.init_rev  = 1'b1;
                    state_next    = S_SRCH;
                end else begin
                    cmd.commit = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_SHRD: begin
                if (stat.sh_more) begin
                    cmd.sh_rd  = 1'b1;
                    state_next = S_SHWR;
                end else begin
                    state_next = S_INS;
                end
            end
            S_SHWR: begin
                cmd.sh_wr  = 1'b1;
                state_next = S_SHRD;
            end
            S_FIN: begin
                if (stat.out_free) begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/spmi_datapath.sv]
// ----------------------------------------------------------------------------
// spmi_datapath
// Sorted tables, binary search registers, shift pointer and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_pair_multiset_index_assert.svh"

module spmi_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  spmi_pkg::mode_t             in_mode,
    input  logic [spmi_pkg::VAL_W-1:0]  in_first,
    input  logic [spmi_pkg::VAL_W-1:0]  in_second,
    input  logic [spmi_pkg::IDX_W-1:0]  in_index,
    input  spmi_pkg::cmd_t              cmd,
    output spmi_pkg::stat_t             stat,
    input  logic                        m_tready,
    output logic                        m_tvalid,
    output spmi_pkg::status_t           out_status,
    output logic [spmi_pkg::COUNT_WIDTH-1:0] out_mult,
    output logic [spmi_pkg::VAL_W-1:0]  out_major,
    output logic [spmi_pkg::VAL_W-1:0]  out_minor,
    output logic [spmi_pkg::CNT_W-1:0]  out_pairs,
    output logic [spmi_pkg::VAL_W-1:0]  out_tuples
);
    import spmi_pkg::*;

    // Table memories: key in the upper bits, count in the lower bits
    logic [ENTRY_W-1:0] fwd_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rev_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] fwd_rd_reg, rev_rd_reg, rdata;

    mode_t              mode_reg;
    logic [VAL_W-1:0]   a_reg, b_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [KEY_W-1:0]   key_reg;
    logic               rev_reg, found_reg, present_reg;
    logic [COUNT_WIDTH-1:0] cnt_reg, mult_reg;
    logic [CNT_W-1:0]   lo_reg, hi_reg, ptr_reg, n_reg;
    logic [VAL_W-1:0]   tuple_reg;
    logic               valid_reg;

    logic [CNT_W-1:0]       mid, ptr_dec;
    logic [IDX_W-1:0]       rd_addr, wr_addr;
    logic [ENTRY_W-1:0]     wr_data;
    logic                   rd_en, wr_en;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [KEY_W-1:0]       rd_key;

    assign rdata   = rev_reg ? rev_rd_reg : fwd_rd_reg;
    assign rd_key  = rdata[ENTRY_W-1:COUNT_WIDTH];
    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign ptr_dec = ptr_reg - CNT_W'(1);
    assign cnt_inc = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + COUNT_WIDTH'(1);

    // Select memory addresses and write data
    always_comb begin
        rd_en   = cmd.srch_rd | cmd.sh_rd | cmd.rd_rd;
        wr_en   = cmd.upd_wr | cmd.sh_wr | cmd.ins_wr;
        rd_addr = idx_reg;
        if (cmd.srch_rd) begin
            rd_addr = mid[IDX_W-1:0];
        end else if (cmd.sh_rd) begin
            rd_addr = ptr_dec[IDX_W-1:0];
        end
        wr_addr = cmd.sh_wr ? ptr_reg[IDX_W-1:0] : lo_reg[IDX_W-1:0];
        if (cmd.sh_wr) begin
            wr_data = rdata;
        end else if (cmd.upd_wr) begin
            wr_data = {key_reg, cnt_inc};
        end else begin
            wr_data = {key_reg, COUNT_WIDTH'(1)};
        end
    end

    // Memory ports
    always_ff @(posedge aclk) begin
        if (wr_en && !rev_reg) begin
            fwd_mem[wr_addr] <= wr_data;
        end
        if (wr_en && rev_reg) begin
            rev_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            fwd_rd_reg <= fwd_mem[rd_addr];
            rev_rd_reg <= rev_mem[rd_addr];
        end
    end

    // Operand, search and shift registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg  <= in_mode;
            a_reg     <= in_first;
            b_reg     <= in_second;
            idx_reg   <= in_index;
            rev_reg   <= (in_mode == MODE_READ_REV);
            key_reg   <= make_key(in_first, in_second);
            lo_reg    <= '0;
            hi_reg    <= n_reg;
            found_reg <= 1'b0;
            mult_reg  <= '0;
        end
        if (cmd.srch_init) begin
            rev_reg   <= cmd.init_rev;
            key_reg   <= cmd.init_rev ? make_key(b_reg, a_reg) : make_key(a_reg, b_reg);
            lo_reg    <= '0;
            hi_reg    <= n_reg;
            found_reg <= 1'b0;
        end
        if (cmd.srch_cmp) begin
            if (rd_key < key_reg) begin
                lo_reg <= mid + CNT_W'(1);
            end else begin
                hi_reg <= mid;
            end
            if (rd_key == key_reg) begin
                found_reg <= 1'b1;
                cnt_reg   <= rdata[COUNT_WIDTH-1:0];
                if (mode_reg == MODE_LOOKUP) begin
                    mult_reg <= rdata[COUNT_WIDTH-1:0];
                end
            end
        end
        if (cmd.sh_init) begin
            ptr_reg <= n_reg;
        end
        if (cmd.sh_wr) begin
            ptr_reg <= ptr_dec;
        end
        // Remember whether the forward pass found the pair
        if ((cmd.upd_wr || cmd.ins_wr) && !rev_reg) begin
            present_reg <= cmd.upd_wr;
            mult_reg    <= cmd.upd_wr ? cnt_inc : COUNT_WIDTH'(1);
        end
    end

    // Stored pair and tuple counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg     <= '0;
            tuple_reg <= '0;
        end else if (cmd.commit) begin
            if (!present_reg) begin
                n_reg <= n_reg + CNT_W'(1);
            end
            if (tuple_reg != '1) begin
                tuple_reg <= tuple_reg + VAL_W'(1);
            end
        end
    end

    // Result register: load on finish, drop on output beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.fin) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin) begin
            out_status <= cmd.fin_status;
            out_pairs  <= n_reg;
            out_tuples <= tuple_reg;
            if (mode_reg inside {MODE_INSERT, MODE_LOOKUP}) begin
                out_mult  <= (cmd.fin_status == STAT_OK) ? mult_reg : '0;
                out_major <= a_reg;
                out_minor <= b_reg;
            end else if (cmd.fin_status == STAT_RANGE) begin
                out_mult  <= '0;
                out_major <= '0;
                out_minor <= '0;
            end else begin
                out_mult  <= rdata[COUNT_WIDTH-1:0];
                out_major <= rdata[ENTRY_W-1:ENTRY_W-VAL_W] ^ SIGN_FLIP;
                out_minor <= rdata[COUNT_WIDTH+VAL_W-1:COUNT_WIDTH] ^ SIGN_FLIP;
            end
        end
    end

    assign m_tvalid = valid_reg;

    // Status to controller
    always_comb begin
        stat          = '0;
        stat.mode     = mode_reg;
        stat.lo_lt_hi = lo_reg < hi_reg;
        stat.found    = found_reg;
        stat.full     = (n_reg == CNT_W'(TABLE_DEPTH));
        stat.sh_more  = ptr_reg > lo_reg;
        stat.idx_ok   = {1'b0, idx_reg} < n_reg;
        stat.rev      = rev_reg;
        stat.out_free = !valid_reg || m_tready;
    end

    `SPMI_ASSERT(a_pairs_bound, aclk, aresetn, n_reg <= CNT_W'(TABLE_DEPTH))
    `SPMI_ASSERT(a_tuples_monotonic, aclk, aresetn, tuple_reg >= $past(tuple_reg))
    `SPMI_ASSERT_NEXT(a_cmp_narrows, aclk, aresetn, cmd.srch_cmp, lo_reg <= hi_reg)

endmodule

[hw/rtl/sorted_pair_multiset_index.sv]
// Sorted pair multiset index.
// Input beats on s_* carry one command: mode in s_tuser, the pair and a table
// index in s_tdata. Every command yields exactly one result beat on m_*.
// Insert adds a pair to the forward (first, second) and reverse
// (second, first) tables in sorted position, or bumps its saturating count.
// Lookup returns a count, and the read modes return the entry at an index.
// Each binary search step is a memory read, then a compare. An insert of a
// new pair runs two searches plus two shifts that move every entry above its
// slot. One command is in flight at a time.
// Reset clears the pair and tuple counters and the result valid flag; the
// tables need no clearing since only stored entries are ever read.
// A finished result waits in the output register while m_tready is low;
// the next command is taken meanwhile and finishes once the slot frees.
// ----------------------------------------------------------------------------
// sorted_pair_multiset_index
// Top level: stream ports, controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_pair_multiset_index (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,  // first_value, second_value, entry_index, zero pad
    input  logic [1:0]   s_tuser,  // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata   // status, multiplicity, entry_major, entry_minor,
                                   // distinct_pairs, tuple_total, zero pad
);
    import spmi_pkg::*;

    cmd_t    cmd;
    stat_t   stat;
    mode_t   in_mode;
    status_t out_status;
    logic [COUNT_WIDTH-1:0] out_mult;
    logic [VAL_W-1:0]       out_major, out_minor, out_tuples;
    logic [CNT_W-1:0]       out_pairs;

    assign in_mode = mode_t'(s_tuser);

    spmi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_mode  (in_mode),
        .stat     (stat),
        .cmd      (cmd)
    );

    spmi_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_mode    (in_mode),
        .in_first   (s_tdata[31:0]),
        .in_second  (s_tdata[63:32]),
        .in_index   (s_tdata[73:64]),
        .cmd        (cmd),
        .stat       (stat),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_status (out_status),
        .out_mult   (out_mult),
        .out_major  (out_major),
        .out_minor  (out_minor),
        .out_pairs  (out_pairs),
        .out_tuples (out_tuples)
    );

    // Pack result beat
    assign m_tdata = {3'b000, out_tuples, out_pairs, out_minor, out_major,
                      out_mult, out_status};

endmodule
